[rtl/core/twc_pkg.sv]
// ----------------------------------------------------------------------------
// twc_pkg
// Shared constants, command codes and sideband types of the tile wipe core.
// ----------------------------------------------------------------------------
package twc_pkg;

	localparam int TILE_SHIFT   = 4;
	localparam int TILE_PX      = 1 << TILE_SHIFT;
	localparam int WINDOW_SHIFT = 2;
	localparam int Q16_ONE      = 65536;
	localparam int SPAN         = Q16_ONE - (Q16_ONE >> WINDOW_SHIFT);

	localparam int CMD_W   = 2;
	localparam int XW      = 9;
	localparam int YW      = 8;
	localparam int PIX_W   = 8;
	localparam int LOAD_W  = 9;
	localparam int PROG_W  = 17;
	localparam int TX_W    = XW - TILE_SHIFT;
	localparam int TY_W    = YW - TILE_SHIFT;

	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_AW    = 4;
	localparam int CNT_W      = 5;
	localparam int PIPE_LAT   = 8;

	localparam logic [CMD_W-1:0] CMD_PIXEL    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PROGRESS = 2'd2;

	localparam logic CFG_DEAL_MODE = 1'b0;
	localparam logic CFG_CURTAIN   = 1'b1;

	typedef struct packed {
		logic                  in_grid;
		logic [TILE_SHIFT-1:0] ox;
		logic [TILE_SHIFT-1:0] oy;
		logic [PIX_W-1:0]      img;
		logic [PROG_W-1:0]     prog;
	} side_t;

endpackage

[rtl/core/twc_rank_mem.sv]
// ----------------------------------------------------------------------------
// twc_rank_mem
// Rank table: one write port, one registered read port, and an identity
// fill sweep after reset during which ready stays low.
// ----------------------------------------------------------------------------
module twc_rank_mem #(
	parameter int DEPTH  = 300,
	parameter int ADDR_W = 9
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [ADDR_W-1:0]         rd_addr,
	output logic [twc_pkg::LOAD_W-1:0] rd_data,
	input  logic                      wr_en,
	input  logic [ADDR_W-1:0]         wr_addr,
	input  logic [twc_pkg::LOAD_W-1:0] wr_data,
	output logic                      ready
);

	localparam int RW = twc_pkg::LOAD_W;

	logic [RW-1:0]     mem [DEPTH];
	logic [RW-1:0]     rd_data_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= RW'(clr_addr_q);
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign ready   = !clr_busy_q;

endmodule

[rtl/core/twc_start_calc.sv]
// ----------------------------------------------------------------------------
// twc_start_calc
// Pipelined start point: rank * SPAN / DIVISOR, split into a whole part and
// a remainder part divided through a reciprocal with one correction step.
// ----------------------------------------------------------------------------
module twc_start_calc #(
	parameter int RANK_W  = 9,
	parameter int DIVISOR = 299,
	parameter int START_W = 17
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_i,
	input  logic [RANK_W-1:0]   rank_i,
	input  twc_pkg::side_t      side_i,
	output logic                valid_o,
	output logic [START_W-1:0]  start_o,
	output twc_pkg::side_t      side_o
);

	localparam int MUL_A = twc_pkg::SPAN / DIVISOR;
	localparam int REM_B = twc_pkg::SPAN % DIVISOR;
	localparam int DW    = $clog2(DIVISOR + 1);
	localparam int SH    = RANK_W + DW;
	localparam int RECIP = (1 << SH) / DIVISOR;
	localparam int R_W   = $clog2(RECIP + 1);
	localparam int MR_W  = SH + R_W;
	localparam logic [R_W-1:0] RECIP_V = R_W'(RECIP);

	logic                 valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	twc_pkg::side_t       side_s2, side_s3, side_s4, side_s5, side_s6;
	logic [RANK_W-1:0]    rank_s2;
	logic [START_W-1:0]   a_s3, a_s4, a_s5, start_s6;
	logic [SH-1:0]        m_s3, m_s4, m_s5, prod_s5;
	logic [RANK_W-1:0]    q0_s4, q0_s5;
	logic [MR_W-1:0]      mr;
	logic [SH-1:0]        rem;
	logic [RANK_W-1:0]    q;

	assign mr  = MR_W'(m_s3) * MR_W'(RECIP_V);
	assign rem = m_s5 - prod_s5;
	assign q   = q0_s5 + RANK_W'(rem >= SH'(DIVISOR));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s2 <= valid_i;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		rank_s2  <= rank_i;
		side_s2  <= side_i;
		a_s3     <= START_W'(rank_s2 * MUL_A);
		m_s3     <= SH'(rank_s2 * REM_B);
		side_s3  <= side_s2;
		q0_s4    <= RANK_W'(mr >> SH);
		m_s4     <= m_s3;
		a_s4     <= a_s3;
		side_s4  <= side_s3;
		prod_s5  <= SH'(q0_s4 * DIVISOR);
		q0_s5    <= q0_s4;
		m_s5     <= m_s4;
		a_s5     <= a_s4;
		side_s5  <= side_s4;
		start_s6 <= a_s5 + START_W'(q);
		side_s6  <= side_s5;
	end

	assign valid_o = valid_s6;
	assign start_o = start_s6;
	assign side_o  = side_s6;

endmodule

[rtl/core/twc_out_fifo.sv]
// ----------------------------------------------------------------------------
// twc_out_fifo
// Result queue between the fixed-latency pipeline and the output channel.
// ----------------------------------------------------------------------------
module twc_out_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [twc_pkg::PIX_W-1:0] wr_data,
	input  logic                      rd_ready,
	output logic                      rd_valid,
	output logic [twc_pkg::PIX_W-1:0] rd_data
);

	localparam int AW = twc_pkg::FIFO_AW;
	localparam int CW = twc_pkg::CNT_W;

	logic [twc_pkg::PIX_W-1:0] buf_q [twc_pkg::FIFO_DEPTH];
	logic [AW-1:0]             wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]             count_q;
	logic                      rd_fire;

	assign rd_valid = (count_q != '0);
	assign rd_fire  = rd_valid && rd_ready;
	assign rd_data  = buf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (rd_fire) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			unique case ({wr_en, rd_fire})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

[rtl/core/tile_wipe_compositor_core.sv]
// ----------------------------------------------------------------------------
// tile_wipe_compositor_core
// Pixel-stream tile wipe: each tile opens as a centered box as the frame
// progress advances; pixels outside the open box show the curtain index.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one command per transaction:
//   a pixel, a rank table load, or a frame progress update. Only a pixel
//   produces a result on the output channel (out_valid/out_ready).
//   Configuration (deal mode, curtain index) is written through cfg_we,
//   cfg_index and cfg_data while the core is idle.
//   Throughput is one transaction per cycle while in_ready is high. A pixel
//   reaches the output queue through a depth set by the rank table read and
//   the five-stage start point divider, followed by the box size and box test
//   stages.
//   Results go into a 16-entry queue; outside the reset fill, in_ready
//   drops only when 16 pixels are in flight or waiting, so a stalled receiver
//   holds input after that point while the pipeline drains into the queue.
//   After reset the rank table is filled with the identity order, one entry
//   per cycle, for all TILES_ACROSS*TILES_DOWN tiles; in_ready stays low until
//   the fill is done. Progress, deal mode and curtain index reset to zero.
// ----------------------------------------------------------------------------
module tile_wipe_compositor_core #(
	parameter int TILES_ACROSS = 20,
	parameter int TILES_DOWN   = 15
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [twc_pkg::CMD_W-1:0]   command,
	input  logic [twc_pkg::XW-1:0]      pixel_x,
	input  logic [twc_pkg::YW-1:0]      pixel_y,
	input  logic [twc_pkg::PIX_W-1:0]   image_pixel,
	input  logic [twc_pkg::LOAD_W-1:0]  load_tile,
	input  logic [twc_pkg::LOAD_W-1:0]  load_rank,
	input  logic [twc_pkg::PROG_W-1:0]  frame_progress,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [twc_pkg::PIX_W-1:0]   out_pixel,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [twc_pkg::PIX_W-1:0]   cfg_data
);

	localparam int TILES      = TILES_ACROSS * TILES_DOWN;
	localparam int ADDR_W     = $clog2(TILES);
	localparam int RANK_W     = (twc_pkg::LOAD_W > ADDR_W) ? twc_pkg::LOAD_W : ADDR_W;
	localparam int DIVISOR    = TILES - 1;
	localparam int START_W    = $clog2(((1 << RANK_W) - 1) * twc_pkg::SPAN / DIVISOR + 1);
	localparam int PW         = twc_pkg::PROG_W;
	localparam int CMP_W      = (START_W > PW) ? START_W : PW;
	localparam int OPEN_W     = PW + twc_pkg::WINDOW_SHIFT;
	localparam int TSH        = twc_pkg::TILE_SHIFT;
	localparam int HSUM_W     = PW + TSH + 1;
	localparam int BOX_W      = TSH + 1;
	localparam int TX_W       = twc_pkg::TX_W;
	localparam int TY_W       = twc_pkg::TY_W;
	localparam int CW         = twc_pkg::CNT_W;
	localparam int HALF_LO    = TILES_ACROSS / 2;
	localparam int HALF_HI    = (TILES_ACROSS + 1) / 2;
	localparam int TOTAL_EVEN = ((TILES_DOWN + 1) / 2) * HALF_HI + (TILES_DOWN / 2) * HALF_LO;

	logic                          in_fire, pix_fire, load_fire, out_fire, mem_ready;
	logic [TX_W-1:0]               tx;
	logic [TY_W-1:0]               ty;
	logic                          in_grid;
	logic [ADDR_W-1:0]             rd_addr;
	logic [twc_pkg::LOAD_W-1:0]    rd_data;

	logic                          deal_mode_q;
	logic [twc_pkg::PIX_W-1:0]     curtain_q;
	logic [PW-1:0]                 progress_q;
	logic [CW-1:0]                 used_q;

	logic                          valid_s1;
	logic [TX_W-1:0]               tx_s1;
	logic [TY_W-1:0]               ty_s1;
	twc_pkg::side_t                side_s1;

	logic                          parity;
	int                            cnt_a, cnt_b, chk_rank;
	logic [RANK_W-1:0]             rank;

	logic                          valid_s6;
	logic [START_W-1:0]            start_s6;
	twc_pkg::side_t                side_s6;

	logic [PW-1:0]                 diff;
	logic [OPEN_W-1:0]             open_sh;
	logic [PW-1:0]                 opening;
	logic [HSUM_W-1:0]             hsum;

	logic                          valid_s7;
	logic [TSH-1:0]                half_s7;
	twc_pkg::side_t                side_s7;

	logic [BOX_W-1:0]              box_lo, box_hi;
	logic                          box_open;
	logic [twc_pkg::PIX_W-1:0]     result;

	// input decode
	assign in_fire   = in_valid && in_ready;
	assign pix_fire  = in_fire && (command == twc_pkg::CMD_PIXEL);
	assign load_fire = in_fire && (command == twc_pkg::CMD_LOAD) && (32'(load_tile) < TILES);
	assign in_ready  = mem_ready && (used_q < CW'(twc_pkg::FIFO_DEPTH));
	assign out_fire  = out_valid && out_ready;

	assign tx      = pixel_x[twc_pkg::XW-1:TSH];
	assign ty      = pixel_y[twc_pkg::YW-1:TSH];
	assign in_grid = (32'(tx) < TILES_ACROSS) && (32'(ty) < TILES_DOWN);
	assign rd_addr = ADDR_W'(32'(ty) * TILES_ACROSS + 32'(tx));

	twc_rank_mem #(
		.DEPTH  (TILES),
		.ADDR_W (ADDR_W)
	) u_rank_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (pix_fire && in_grid),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (load_fire),
		.wr_addr (ADDR_W'(load_tile)),
		.wr_data (load_rank),
		.ready   (mem_ready)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deal_mode_q <= 1'b0;
			curtain_q   <= '0;
			progress_q  <= '0;
			used_q      <= '0;
			valid_s1    <= 1'b0;
			valid_s7    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					twc_pkg::CFG_DEAL_MODE: deal_mode_q <= cfg_data[0];
					twc_pkg::CFG_CURTAIN:   curtain_q   <= cfg_data;
				endcase
			end
			if (in_fire && (command == twc_pkg::CMD_PROGRESS)) begin
				progress_q <= frame_progress;
			end
			unique case ({pix_fire, out_fire})
				2'b10:   used_q <= used_q + CW'(1);
				2'b01:   used_q <= used_q - CW'(1);
				default: used_q <= used_q;
			endcase
			valid_s1 <= pix_fire;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		tx_s1           <= tx;
		ty_s1           <= ty;
		side_s1.in_grid <= in_grid;
		side_s1.ox      <= pixel_x[TSH-1:0];
		side_s1.oy      <= pixel_y[TSH-1:0];
		side_s1.img     <= image_pixel;
		side_s1.prog    <= progress_q;
	end

	// checkerboard deal order
	always_comb begin
		parity   = tx_s1[0] ^ ty_s1[0];
		cnt_a    = parity ? HALF_LO : HALF_HI;
		cnt_b    = parity ? HALF_HI : HALF_LO;
		chk_rank = ((int'(ty_s1) + 1) >> 1) * cnt_a + (int'(ty_s1) >> 1) * cnt_b
			+ (int'(tx_s1) >> 1) + (parity ? TOTAL_EVEN : 0);
		rank     = deal_mode_q ? RANK_W'(chk_rank) : RANK_W'(rd_data);
	end

	twc_start_calc #(
		.RANK_W  (RANK_W),
		.DIVISOR (DIVISOR),
		.START_W (START_W)
	) u_start_calc (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (valid_s1),
		.rank_i  (rank),
		.side_i  (side_s1),
		.valid_o (valid_s6),
		.start_o (start_s6),
		.side_o  (side_s6)
	);

	// box half size from progress
	always_comb begin
		diff    = (CMP_W'(side_s6.prog) > CMP_W'(start_s6))
			? PW'(CMP_W'(side_s6.prog) - CMP_W'(start_s6)) : '0;
		open_sh = OPEN_W'(diff) << twc_pkg::WINDOW_SHIFT;
		opening = (open_sh > OPEN_W'(twc_pkg::Q16_ONE)) ? PW'(twc_pkg::Q16_ONE) : PW'(open_sh);
		hsum    = (HSUM_W'(opening) << TSH) + HSUM_W'(twc_pkg::Q16_ONE);
	end

	always_ff @(posedge clk) begin
		half_s7 <= TSH'(hsum >> PW);
		side_s7 <= side_s6;
	end

	// box test and select
	always_comb begin
		box_lo   = BOX_W'(twc_pkg::TILE_PX / 2) - BOX_W'(half_s7);
		box_hi   = BOX_W'(twc_pkg::TILE_PX / 2) + BOX_W'(half_s7);
		box_open = side_s7.in_grid
			&& (BOX_W'(side_s7.ox) >= box_lo) && (BOX_W'(side_s7.ox) < box_hi)
			&& (BOX_W'(side_s7.oy) >= box_lo) && (BOX_W'(side_s7.oy) < box_hi);
		result   = box_open ? side_s7.img : curtain_q;
	end

	twc_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (valid_s7),
		.wr_data  (result),
		.rd_ready (out_ready),
		.rd_valid (out_valid),
		.rd_data  (out_pixel)
	);

endmodule

[rtl/core/twc_checker.sv]
// ----------------------------------------------------------------------------
// twc_checker
// Port-level checks of the tile wipe core, attached by bind.
// ----------------------------------------------------------------------------
module twc_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic [twc_pkg::CMD_W-1:0] command,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [twc_pkg::PIX_W-1:0] out_pixel
);

	// a waiting result transaction holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pixel))
		else $error("output changed while stalled");

	// only a pixel transaction consumes queue credit
	a_ready_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !(in_valid && command == twc_pkg::CMD_PIXEL) |=> in_ready)
		else $error("in_ready dropped without a pixel transaction");

	// every pixel reaches the output queue after the fixed pipeline depth
	a_pixel_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == twc_pkg::CMD_PIXEL
		|-> ##(twc_pkg::PIPE_LAT) out_valid)
		else $error("pixel result missing after pipeline latency");

endmodule

bind tile_wipe_compositor_core twc_checker u_twc_checker (.*);

[verif/tb_tile_wipe_compositor_core.sv]
// ----------------------------------------------------------------------------
// tb_tile_wipe_compositor_core
// Self-checking testbench for the tile wipe core. A directed sequence covers
// the grid corners, out-of-grid pixels, ignored loads and commands, oversized
// ranks and progress values. Several configuration phases of random commands
// follow, with bursty input and a stalling receiver. Each output pixel is
// compared in order against a predictor that tracks the rank table, the
// frame progress and the configuration.
// ----------------------------------------------------------------------------
module tb_tile_wipe_compositor_core;

	localparam int TILES_ACROSS = 20;
	localparam int TILES_DOWN   = 15;
	localparam int TILE_COUNT   = TILES_ACROSS * TILES_DOWN;
	localparam int CLK_PERIOD   = 12;
	localparam int LIMIT_CYCLES = 400000;
	localparam int PHASE_ITEMS  = 360;
	localparam int HOLD_CYCLES  = 240;

	localparam logic [twc_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	typedef struct {
		logic [twc_pkg::CMD_W-1:0]  cmd;
		logic [twc_pkg::XW-1:0]     x;
		logic [twc_pkg::YW-1:0]     y;
		logic [twc_pkg::PIX_W-1:0]  img;
		logic [twc_pkg::LOAD_W-1:0] tile;
		logic [twc_pkg::LOAD_W-1:0] rank;
		logic [twc_pkg::PROG_W-1:0] prog;
	} wipe_cmd_t;

	class wipe_scoreboard_t;
		logic [twc_pkg::LOAD_W-1:0] rank_table [TILE_COUNT];
		logic [twc_pkg::PROG_W-1:0] progress;
		logic                       deal_checker;
		logic [twc_pkg::PIX_W-1:0]  curtain;
		logic [twc_pkg::PIX_W-1:0]  expected_pixels [$];
		int                         failures;

		function new();
			foreach (rank_table[i]) rank_table[i] = twc_pkg::LOAD_W'(i);
			progress = '0;
			deal_checker = 1'b0;
			curtain = '0;
			failures = 0;
		endfunction

		function void set_config(logic deal, logic [twc_pkg::PIX_W-1:0] curtain_value);
			deal_checker = deal;
			curtain = curtain_value;
		endfunction

		function int unsigned tile_rank(int unsigned tx, int unsigned ty);
			if (deal_checker) begin
				return ((tx + ty) % 2) * (TILE_COUNT / 2) + ty * (TILES_ACROSS / 2) + tx / 2;
			end
			return rank_table[ty * TILES_ACROSS + tx];
		endfunction

		function logic [twc_pkg::PIX_W-1:0] predict_pixel(wipe_cmd_t c);
			int unsigned tx, ty;
			longint start_pt, opening;
			int half, cx, cy, px, py;
			tx = c.x / twc_pkg::TILE_PX;
			ty = c.y / twc_pkg::TILE_PX;
			if (tx >= TILES_ACROSS || ty >= TILES_DOWN) begin
				return curtain;
			end
			start_pt = longint'(tile_rank(tx, ty)) * twc_pkg::SPAN / (TILE_COUNT - 1);
			if (longint'(progress) <= start_pt) begin
				opening = 0;
			end else begin
				opening = (longint'(progress) - start_pt) << twc_pkg::WINDOW_SHIFT;
			end
			if (opening > twc_pkg::Q16_ONE) begin
				opening = twc_pkg::Q16_ONE;
			end
			half = int'((opening * twc_pkg::TILE_PX + twc_pkg::Q16_ONE) >> 17);
			cx = int'(tx) * twc_pkg::TILE_PX + twc_pkg::TILE_PX / 2;
			cy = int'(ty) * twc_pkg::TILE_PX + twc_pkg::TILE_PX / 2;
			px = int'(c.x);
			py = int'(c.y);
			if (px >= cx - half && px < cx + half && py >= cy - half && py < cy + half) begin
				return c.img;
			end
			return curtain;
		endfunction

		function void note_input(wipe_cmd_t c);
			case (c.cmd)
				twc_pkg::CMD_PIXEL: begin
					expected_pixels.push_back(predict_pixel(c));
				end
				twc_pkg::CMD_LOAD: begin
					if (c.tile < TILE_COUNT) rank_table[c.tile] = c.rank;
				end
				twc_pkg::CMD_PROGRESS: begin
					progress = c.prog;
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic [twc_pkg::PIX_W-1:0] actual);
			logic [twc_pkg::PIX_W-1:0] want;
			if (expected_pixels.size() == 0) begin
				$error("out_pixel: no expected transaction, actual %0d", actual);
				failures++;
				return;
			end
			want = expected_pixels.pop_front();
			if (actual !== want) begin
				$error("out_pixel mismatch: expected %0d, actual %0d", want, actual);
				failures++;
			end
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [twc_pkg::CMD_W-1:0]  command = '0;
	logic [twc_pkg::XW-1:0]     pixel_x = '0;
	logic [twc_pkg::YW-1:0]     pixel_y = '0;
	logic [twc_pkg::PIX_W-1:0]  image_pixel = '0;
	logic [twc_pkg::LOAD_W-1:0] load_tile = '0;
	logic [twc_pkg::LOAD_W-1:0] load_rank = '0;
	logic [twc_pkg::PROG_W-1:0] frame_progress = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [twc_pkg::PIX_W-1:0]  out_pixel;
	logic                       cfg_we = 1'b0;
	logic                       cfg_index = twc_pkg::CFG_DEAL_MODE;
	logic [twc_pkg::PIX_W-1:0]  cfg_data = '0;

	wipe_scoreboard_t sb = new();
	int               burst_left = 0;
	bit               long_hold_req = 1'b0;
	int               hold_left = 0;
	int               mode_left = 0;
	rx_mode_t         stall_mode = RX_ALWAYS;

	tile_wipe_compositor_core #(
		.TILES_ACROSS(TILES_ACROSS),
		.TILES_DOWN  (TILES_DOWN)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.image_pixel   (image_pixel),
		.load_tile     (load_tile),
		.load_rank     (load_rank),
		.frame_progress(frame_progress),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_pixel     (out_pixel),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("tile_wipe_compositor_core regression: fail");
		$finish;
	end

	// output channel: stall pattern plus a single long hold-off
	always @(posedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 128);
			end
			mode_left--;
			case (stall_mode)
				RX_ALWAYS: out_ready <= 1'b1;
				RX_COIN: out_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= (mode_left % 5 != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_pixel);
	end

	function automatic wipe_cmd_t mk(logic [twc_pkg::CMD_W-1:0] cmd, int x, int y, int img,
			int tile, int rank, int prog);
		wipe_cmd_t c;
		c.cmd = cmd;
		c.x = twc_pkg::XW'(x);
		c.y = twc_pkg::YW'(y);
		c.img = twc_pkg::PIX_W'(img);
		c.tile = twc_pkg::LOAD_W'(tile);
		c.rank = twc_pkg::LOAD_W'(rank);
		c.prog = twc_pkg::PROG_W'(prog);
		return c;
	endfunction

	function automatic wipe_cmd_t random_cmd();
		wipe_cmd_t c;
		int unsigned roll;
		c = mk(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		roll = $urandom_range(0, 99);
		if (roll < 70) begin
			c.cmd = twc_pkg::CMD_PIXEL;
			if ($urandom_range(0, 9) != 0) begin
				c.x = twc_pkg::XW'($urandom_range(0, TILES_ACROSS * twc_pkg::TILE_PX - 1));
				c.y = twc_pkg::YW'($urandom_range(0, TILES_DOWN * twc_pkg::TILE_PX - 1));
			end
		end else if (roll < 80) begin
			c.cmd = twc_pkg::CMD_LOAD;
			if ($urandom_range(0, 9) != 0) begin
				c.tile = twc_pkg::LOAD_W'($urandom_range(0, TILE_COUNT - 1));
			end
			if ($urandom_range(0, 6) != 0) begin
				c.rank = twc_pkg::LOAD_W'($urandom_range(0, TILE_COUNT - 1));
			end
		end else if (roll < 93) begin
			c.cmd = twc_pkg::CMD_PROGRESS;
			case ($urandom_range(0, 9))
				0: c.prog = '0;
				1: c.prog = twc_pkg::PROG_W'(twc_pkg::Q16_ONE);
				2: ;
				default: c.prog = twc_pkg::PROG_W'($urandom_range(0, twc_pkg::Q16_ONE));
			endcase
		end
		return c;
	endfunction

	task automatic send_cmd(wipe_cmd_t c);
		in_valid <= 1'b1;
		command <= c.cmd;
		pixel_x <= c.x;
		pixel_y <= c.y;
		image_pixel <= c.img;
		load_tile <= c.tile;
		load_rank <= c.rank;
		frame_progress <= c.prog;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(c);
	endtask

	task automatic offer_cmd(wipe_cmd_t c);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 8);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		burst_left--;
		send_cmd(c);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.expected_pixels.size() != 0) @(posedge clk);
		repeat (twc_pkg::PIPE_LAT + 4) @(posedge clk);
	endtask

	task automatic write_config(logic deal, logic [twc_pkg::PIX_W-1:0] curtain_value);
		cfg_we <= 1'b1;
		cfg_index <= twc_pkg::CFG_DEAL_MODE;
		cfg_data <= twc_pkg::PIX_W'(deal);
		@(posedge clk);
		cfg_index <= twc_pkg::CFG_CURTAIN;
		cfg_data <= curtain_value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_config(deal, curtain_value);
	endtask

	initial begin
		wipe_cmd_t c;
		int done_items;
		int step;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		write_config(1'b0, 8'h5A);

		// corners, off-grid pixels, ignored loads and commands, oversized values
		send_cmd(mk(twc_pkg::CMD_PIXEL, 0, 0, 8'hA5, 0, 0, 0));
		send_cmd(mk(twc_pkg::CMD_PIXEL, 511, 255, 8'hFF, 0, 0, 0));
		send_cmd(mk(twc_pkg::CMD_PROGRESS, 0, 0, 0, 0, 0, twc_pkg::Q16_ONE));
		send_cmd(mk(twc_pkg::CMD_PIXEL, 0, 0, 8'hFF, 0, 0, 0));
		send_cmd(mk(twc_pkg::CMD_PIXEL, 319, 239, 8'h00, 0, 0, 0));
		send_cmd(mk(twc_pkg::CMD_PIXEL, 320, 0, 8'h11, 0, 0, 0));
		send_cmd(mk(twc_pkg::CMD_PIXEL, 0, 240, 8'h22, 0, 0, 0));
		send_cmd(mk(twc_pkg::CMD_LOAD, 0, 0, 0, TILE_COUNT - 1, 511, 0));
		send_cmd(mk(twc_pkg::CMD_PIXEL, 319, 239, 8'h33, 0, 0, 0));
		send_cmd(mk(twc_pkg::CMD_LOAD, 0, 0, 0, TILE_COUNT, 0, 0));
		send_cmd(mk(twc_pkg::CMD_LOAD, 0, 0, 0, 511, 0, 0));
		send_cmd(mk(CMD_UNUSED, 511, 255, 255, 0, 0, 0));
		send_cmd(mk(twc_pkg::CMD_PIXEL, 0, 0, 8'h44, 0, 0, 0));
		send_cmd(mk(twc_pkg::CMD_PROGRESS, 0, 0, 0, 0, 0, 131071));
		send_cmd(mk(twc_pkg::CMD_PIXEL, 319, 239, 8'h55, 0, 0, 0));
		send_cmd(mk(twc_pkg::CMD_PROGRESS, 0, 0, 0, 0, 0, 16384));
		send_cmd(mk(twc_pkg::CMD_PIXEL, 246, 54, 8'h66, 0, 0, 0));
		send_cmd(mk(twc_pkg::CMD_PIXEL, 245, 54, 8'h77, 0, 0, 0));
		send_cmd(mk(twc_pkg::CMD_PIXEL, 249, 57, 8'h88, 0, 0, 0));
		send_cmd(mk(twc_pkg::CMD_PIXEL, 250, 54, 8'h99, 0, 0, 0));
		send_cmd(mk(twc_pkg::CMD_LOAD, 0, 0, 0, 0, TILE_COUNT - 1, 0));
		send_cmd(mk(twc_pkg::CMD_PIXEL, 8, 8, 8'hAA, 0, 0, 0));
		send_cmd(mk(twc_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 0));
		send_cmd(mk(twc_pkg::CMD_PROGRESS, 0, 0, 0, 0, 0, 0));

		for (int phase = 0; phase < 5; phase++) begin
			drain_results();
			case (phase)
				0: write_config(1'b0, 8'h00);
				1: write_config(1'b1, 8'hFF);
				2: write_config(1'b0, twc_pkg::PIX_W'($urandom));
				3: write_config(1'b1, twc_pkg::PIX_W'($urandom));
				default: write_config(1'b0, 8'hFF);
			endcase
			done_items = 0;
			step = 0;
			while (done_items < PHASE_ITEMS) begin
				if (phase == 1 && step == 100) long_hold_req = 1'b1;
				if (phase == 3 && step == 200) drain_results();
				c = random_cmd();
				offer_cmd(c);
				if (c.cmd != CMD_UNUSED
						&& !(c.cmd == twc_pkg::CMD_LOAD && c.tile >= TILE_COUNT)) begin
					done_items++;
				end
				step++;
			end
		end

		drain_results();
		if (sb.failures == 0) begin
			$display("tile_wipe_compositor_core regression: pass");
		end else begin
			$display("tile_wipe_compositor_core regression: fail");
		end
		$finish;
	end

endmodule
